// ===== rtl/mpp_pkg.sv =====
// Shared types and constants for the path mapping block.
// Holds the request, response and segment entry structs and the code names.
// No dependencies.
`default_nettype none

package mpp_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   // Internal value width: holds +-2^40 saturated terms plus headroom.
   localparam int VW = 44;
   // Operand magnitude width of the shared multiplier and its product width.
   localparam int MW = 42;
   localparam int PW = 2 * MW;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] KIND_MOVE  = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_CURVE = 2'd2;
   localparam logic [1:0] KIND_CLOSE = 2'd3;

   localparam logic [2:0] STAT_MAPPED  = 3'd0;
   localparam logic [2:0] STAT_PASS    = 3'd1;
   localparam logic [2:0] STAT_STORED  = 3'd2;
   localparam logic [2:0] STAT_FULL    = 3'd3;
   localparam logic [2:0] STAT_CLEARED = 3'd4;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [1:0]         seg_kind;
      logic signed [31:0] ctrl1_x;
      logic signed [31:0] ctrl1_y;
      logic signed [31:0] ctrl2_x;
      logic signed [31:0] ctrl2_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic [30:0]        seg_length;
      logic signed [31:0] query_x;
      logic signed [31:0] query_y;
   } mpp_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic [2:0]         status;
   } mpp_rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] p0;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
      logic signed [31:0] p3;
      logic signed [31:0] p4;
      logic signed [31:0] p5;
      logic [30:0]        len;
   } mpp_seg_type;

endpackage

`default_nettype wire

// ===== rtl/map_point_onto_path_core.sv =====
// Top level of the path mapping block: segment memory, walk and arithmetic.
// Imports mpp_pkg for the payload structs and code constants.
// Clear and append pass through the output state to a registered result. A query reads
// and compares each walked segment in turn (memory read then compare), then maps a line
// or a curve with the shared bit-serial multiply, divide and square root unit.
// One item is worked on at a time; a waiting result does not block the next accept.
// Reset clears the segment count and the handshake state; the memory is not cleared.
`default_nettype none

module map_point_onto_path_core
   import mpp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire mpp_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output mpp_rsp_type      rsp_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WAIT  = 4'd1;
   localparam logic [3:0] ST_EVAL  = 4'd2;
   localparam logic [3:0] ST_SETUP = 4'd3;
   localparam logic [3:0] ST_ISSUE = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_RED   = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_POST  = 4'd8;
   localparam logic [3:0] ST_NORM  = 4'd9;
   localparam logic [3:0] ST_SQRT  = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   localparam logic [4:0] S_L0  = 5'd0;
   localparam logic [4:0] S_L1  = 5'd1;
   localparam logic [4:0] S_L2  = 5'd2;
   localparam logic [4:0] S_L3  = 5'd3;
   localparam logic [4:0] S_T   = 5'd4;
   localparam logic [4:0] S_X0  = 5'd5;
   localparam logic [4:0] S_X1  = 5'd6;
   localparam logic [4:0] S_X2  = 5'd7;
   localparam logic [4:0] S_Y0  = 5'd8;
   localparam logic [4:0] S_Y1  = 5'd9;
   localparam logic [4:0] S_Y2  = 5'd10;
   localparam logic [4:0] S_GX0 = 5'd11;
   localparam logic [4:0] S_GX1 = 5'd12;
   localparam logic [4:0] S_GY0 = 5'd13;
   localparam logic [4:0] S_GY1 = 5'd14;
   localparam logic [4:0] S_SQX = 5'd15;
   localparam logic [4:0] S_SQY = 5'd16;
   localparam logic [4:0] S_OX  = 5'd17;
   localparam logic [4:0] S_OY  = 5'd18;

   localparam logic [1:0] MD_T    = 2'd0;
   localparam logic [1:0] MD_DIVL = 2'd1;
   localparam logic [1:0] MD_DIVN = 2'd2;
   localparam logic [1:0] MD_RAW  = 2'd3;

   localparam logic signed [VW-1:0] SAT_POS = 44'sh100_0000_0000;
   localparam logic signed [VW-1:0] SAT_NEG = -SAT_POS;
   localparam logic signed [VW-1:0] ONE_T   = 44'sh000_4000_0000;
   localparam logic [40:0]          SAT_MAG = 41'h100_0000_0000;
   localparam logic [63:0]          SQRT_TOP = 64'h4000_0000_0000_0000;

   function automatic logic signed [VW-1:0] clamp_v(input logic signed [VW-1:0] v);
      if (v > SAT_POS) return SAT_POS;
      else if (v < SAT_NEG) return SAT_NEG;
      else return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
      if (v > 44'sh000_7FFF_FFFF) return 32'sh7FFF_FFFF;
      else if (v < -44'sh000_8000_0000) return -32'sh8000_0000;
      else return v[31:0];
   endfunction

   function automatic logic [VW-1:0] abs_v(input logic signed [VW-1:0] v);
      return v[VW-1] ? VW'(-v) : VW'(v);
   endfunction

   function automatic logic signed [VW-1:0] times3(input logic signed [VW-1:0] v);
      return (v <<< 1) + v;
   endfunction

   mpp_seg_type mem [MAX_SEGMENTS];
   mpp_seg_type mem_q_ff;
   logic        mem_we;
   mpp_seg_type mem_wdata;

   logic [3:0]             state_ff, state_in;
   logic [4:0]             step_ff, step_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic signed [31:0]     qy_ff, qy_in;
   logic signed [VW-1:0]   tx_ff, tx_in;
   logic signed [31:0]     cx_ff, cx_in, cy_ff, cy_in, mx_ff, mx_in, my_ff, my_in;
   logic signed [VW-1:0]   c1x_ff, c1x_in, c1y_ff, c1y_in;
   logic signed [VW-1:0]   c2x_ff, c2x_in, c2y_ff, c2y_in;
   logic signed [VW-1:0]   c3x_ff, c3x_in, c3y_ff, c3y_in;
   logic signed [VW-1:0]   t_ff, t_in, h_ff, h_in, gx_ff, gx_in;
   logic signed [VW-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic [2:0]             st_ff, st_in;
   logic [MW-1:0]          ux_ff, ux_in, uy_ff, uy_in;
   logic                   gxn_ff, gxn_in, gyn_ff, gyn_in;
   logic [63:0]            sq_ff, sq_in, sroot_ff, sroot_in, sbit_ff, sbit_in;
   logic [1:0]             mode_ff, mode_in;
   logic [PW-1:0]          ma_ff, ma_in, prod_ff, prod_in;
   logic [MW-1:0]          mb_ff, mb_in;
   logic                   neg_ff, neg_in;
   logic [5:0]             ucnt_ff, ucnt_in;
   logic [31:0]            dvs_ff, dvs_in, rem_ff, rem_in;
   logic [40:0]            quo_ff, quo_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mpp_rsp_type            rsp_data_ff, rsp_data_in;

   // Working values shared by the combinational block.
   logic signed [VW-1:0] p0v, p1v, p2v, p3v, p4v, p5v, cxv, cyv, lenv, walk_len;
   logic signed [VW-1:0] op_a, op_b, res, gy_new, d0x, d0y;
   logic [1:0]           op_mode;
   logic [VW-1:0]        mag_a, mag_b;
   logic [40:0]          qm;
   logic [MW-1:0]        mx_mag;
   logic [32:0]          rem_sh;
   logic [63:0]          sq_try;
   logic                 walk_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mem_wdata.kind = req_data.seg_kind;
   assign mem_wdata.p0   = req_data.ctrl1_x;
   assign mem_wdata.p1   = req_data.ctrl1_y;
   assign mem_wdata.p2   = req_data.ctrl2_x;
   assign mem_wdata.p3   = req_data.ctrl2_y;
   assign mem_wdata.p4   = req_data.end_x;
   assign mem_wdata.p5   = req_data.end_y;
   assign mem_wdata.len  = req_data.seg_length;
   assign mem_we = req_valid && req_ready && (req_data.opcode == OP_APPEND) &&
                   (cnt_ff < CNT_W'(MAX_SEGMENTS));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cnt_ff[IDX_W-1:0]] <= mem_wdata;
      end
      mem_q_ff <= mem[idx_ff];
   end

   always_comb begin
      p0v = VW'(mem_q_ff.p0);
      p1v = VW'(mem_q_ff.p1);
      p2v = VW'(mem_q_ff.p2);
      p3v = VW'(mem_q_ff.p3);
      p4v = VW'(mem_q_ff.p4);
      p5v = VW'(mem_q_ff.p5);
      cxv = VW'(cx_ff);
      cyv = VW'(cy_ff);
      lenv = VW'({1'b0, mem_q_ff.len});
      walk_len = (mem_q_ff.kind == KIND_MOVE) ? '0 : lenv;
      walk_last = ((CNT_W'(idx_ff) + CNT_W'(1)) >= cnt_ff);
      d0x = p0v - cxv;
      d0y = p1v - cyv;

      // Operand selection for each arithmetic step.
      op_a = t_ff;
      op_b = t_ff;
      op_mode = MD_T;
      case (step_ff)
         S_L0: begin op_a = c1x_ff; op_b = tx_ff; op_mode = MD_DIVL; end
         S_L1: begin op_a = c1y_ff; op_b = VW'(qy_ff); op_mode = MD_DIVL; end
         S_L2: begin op_a = c1y_ff; op_b = tx_ff; op_mode = MD_DIVL; end
         S_L3: begin op_a = c1x_ff; op_b = VW'(qy_ff); op_mode = MD_DIVL; end
         S_T:  begin op_a = tx_ff; op_b = ONE_T; op_mode = MD_DIVL; end
         S_X0: op_a = c3x_ff;
         S_Y0: op_a = c3y_ff;
         S_GX0: op_a = times3(c3x_ff);
         S_GY0: op_a = times3(c3y_ff);
         S_X1, S_X2, S_Y1, S_Y2, S_GX1, S_GY1: op_a = h_ff;
         S_SQX: begin
            op_a = VW'(ux_ff); op_b = VW'(ux_ff); op_mode = MD_RAW;
         end
         S_SQY: begin
            op_a = VW'(uy_ff); op_b = VW'(uy_ff); op_mode = MD_RAW;
         end
         S_OX: begin
            op_a = gyn_ff ? -VW'(uy_ff) : VW'(uy_ff);
            op_b = VW'(qy_ff); op_mode = MD_DIVN;
         end
         S_OY: begin
            op_a = gxn_ff ? -VW'(ux_ff) : VW'(ux_ff);
            op_b = VW'(qy_ff); op_mode = MD_DIVN;
         end
         default: op_mode = MD_T;
      endcase
      mag_a = abs_v(op_a);
      mag_b = abs_v(op_b);

      qm = (quo_ff > SAT_MAG) ? SAT_MAG : quo_ff;
      res = neg_ff ? -VW'(qm) : VW'(qm);
      gy_new = clamp_v(res + c1y_ff);
      mx_mag = (ux_ff > uy_ff) ? ux_ff : uy_ff;
      rem_sh = {rem_ff, prod_ff[40]};
      sq_try = sroot_ff + sbit_ff;

      state_in = state_ff;
      step_in = step_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      qy_in = qy_ff;
      tx_in = tx_ff;
      cx_in = cx_ff; cy_in = cy_ff; mx_in = mx_ff; my_in = my_ff;
      c1x_in = c1x_ff; c1y_in = c1y_ff; c2x_in = c2x_ff; c2y_in = c2y_ff;
      c3x_in = c3x_ff; c3y_in = c3y_ff;
      t_in = t_ff; h_in = h_ff; gx_in = gx_ff;
      ax_in = ax_ff; ay_in = ay_ff; st_in = st_ff;
      ux_in = ux_ff; uy_in = uy_ff; gxn_in = gxn_ff; gyn_in = gyn_ff;
      sq_in = sq_ff; sroot_in = sroot_ff; sbit_in = sbit_ff;
      mode_in = mode_ff; ma_in = ma_ff; mb_in = mb_ff; prod_in = prod_ff;
      neg_in = neg_ff; ucnt_in = ucnt_ff; dvs_in = dvs_ff; rem_in = rem_ff;
      quo_in = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ax_in = '0;
               ay_in = '0;
               unique case (req_data.opcode)
                  OP_CLEAR: begin
                     cnt_in = '0;
                     st_in = STAT_CLEARED;
                     state_in = ST_OUT;
                  end
                  OP_APPEND: begin
                     if (mem_we) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                        st_in = STAT_STORED;
                     end else begin
                        st_in = STAT_FULL;
                     end
                     state_in = ST_OUT;
                  end
                  OP_QUERY: begin
                     qy_in = req_data.query_y;
                     tx_in = VW'(req_data.query_x);
                     ax_in = VW'(req_data.query_x);
                     ay_in = VW'(req_data.query_y);
                     cx_in = '0; cy_in = '0; mx_in = '0; my_in = '0;
                     st_in = STAT_PASS;
                     idx_in = '0;
                     state_in = (cnt_ff == '0) ? ST_OUT : ST_WAIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WAIT: state_in = ST_EVAL;
         ST_EVAL: begin
            if (walk_last || (mem_q_ff.kind != KIND_MOVE && tx_ff <= lenv)) begin
               // A walk that ends on a move leaves the point as it came in.
               state_in = (mem_q_ff.kind == KIND_MOVE) ? ST_OUT : ST_SETUP;
            end else begin
               tx_in = tx_ff - walk_len;
               case (mem_q_ff.kind)
                  KIND_MOVE: begin
                     cx_in = mem_q_ff.p0; mx_in = mem_q_ff.p0;
                     cy_in = mem_q_ff.p1; my_in = mem_q_ff.p1;
                  end
                  KIND_LINE: begin cx_in = mem_q_ff.p0; cy_in = mem_q_ff.p1; end
                  KIND_CURVE: begin cx_in = mem_q_ff.p4; cy_in = mem_q_ff.p5; end
                  default: begin cx_in = mx_ff; cy_in = my_ff; end
               endcase
               idx_in = idx_ff + IDX_W'(1);
               state_in = ST_WAIT;
            end
         end
         ST_SETUP: begin
            st_in = STAT_MAPPED;
            ax_in = cxv;
            ay_in = cyv;
            if (mem_q_ff.len == '0) begin
               state_in = ST_OUT;
            end else if (mem_q_ff.kind == KIND_CURVE) begin
               c1x_in = times3(d0x);
               c1y_in = times3(d0y);
               c2x_in = times3(p2v - (p0v <<< 1) + cxv);
               c2y_in = times3(p3v - (p1v <<< 1) + cyv);
               c3x_in = p4v - times3(p2v) + times3(p0v) - cxv;
               c3y_in = p5v - times3(p3v) + times3(p1v) - cyv;
               step_in = S_T;
               state_in = ST_ISSUE;
            end else begin
               c1x_in = ((mem_q_ff.kind == KIND_LINE) ? p0v : VW'(mx_ff)) - cxv;
               c1y_in = ((mem_q_ff.kind == KIND_LINE) ? p1v : VW'(my_ff)) - cyv;
               step_in = S_L0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            mode_in = op_mode;
            ma_in = PW'(mag_a[MW-1:0]);
            mb_in = mag_b[MW-1:0];
            prod_in = '0;
            neg_in = op_a[VW-1] ^ op_b[VW-1];
            ucnt_in = 6'(MW - 1);
            dvs_in = (op_mode == MD_DIVN) ? sroot_ff[31:0] : {1'b0, mem_q_ff.len};
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mb_ff[0]) begin
               prod_in = prod_ff + ma_ff;
            end
            ma_in = ma_ff << 1;
            mb_in = mb_ff >> 1;
            ucnt_in = ucnt_ff - 6'd1;
            if (ucnt_ff == '0) begin
               state_in = ST_RED;
            end
         end
         ST_RED: begin
            state_in = ST_POST;
            if (mode_ff == MD_T) begin
               quo_in = (prod_ff[PW-1:30] > 54'(SAT_MAG)) ? SAT_MAG : prod_ff[70:30];
            end else if (mode_ff != MD_RAW) begin
               // A quotient of 2^41 or more is known to saturate up front.
               if (prod_ff[PW-1:41] >= 43'(dvs_ff)) begin
                  quo_in = SAT_MAG;
               end else begin
                  rem_in = prod_ff[72:41];
                  quo_in = '0;
                  ucnt_in = 6'd40;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = 32'(rem_sh - {1'b0, dvs_ff});
               quo_in = {quo_ff[39:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               quo_in = {quo_ff[39:0], 1'b0};
            end
            prod_in = prod_ff << 1;
            ucnt_in = ucnt_ff - 6'd1;
            if (ucnt_ff == '0) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            step_in = step_ff + 5'd1;
            state_in = ST_ISSUE;
            case (step_ff)
               S_L0: ax_in = cxv + res;
               S_L1: ax_in = ax_ff - res;
               S_L2: ay_in = cyv + res;
               S_L3: begin ay_in = ay_ff + res; state_in = ST_OUT; end
               S_T:  t_in = res;
               S_X0: h_in = clamp_v(res + c2x_ff);
               S_X1: h_in = clamp_v(res + c1x_ff);
               S_X2: ax_in = cxv + res;
               S_Y0: h_in = clamp_v(res + c2y_ff);
               S_Y1: h_in = clamp_v(res + c1y_ff);
               S_Y2: ay_in = cyv + res;
               S_GX0: h_in = clamp_v(res + (c2x_ff <<< 1));
               S_GX1: gx_in = clamp_v(res + c1x_ff);
               S_GY0: h_in = clamp_v(res + (c2y_ff <<< 1));
               S_GY1: begin
                  ux_in = MW'(abs_v(gx_ff));
                  uy_in = MW'(abs_v(gy_new));
                  gxn_in = gx_ff[VW-1];
                  gyn_in = gy_new[VW-1];
                  state_in = ST_NORM;
               end
               S_SQX: sq_in = prod_ff[63:0];
               S_SQY: begin
                  sq_in = sq_ff + prod_ff[63:0];
                  sroot_in = '0;
                  sbit_in = SQRT_TOP;
                  ucnt_in = 6'd31;
                  state_in = ST_SQRT;
               end
               S_OX: ax_in = ax_ff - res;
               S_OY: begin ay_in = ay_ff + res; state_in = ST_OUT; end
               default: state_in = ST_OUT;
            endcase
         end
         ST_NORM: begin
            // Scale the gradient so its larger component lies in [2^30, 2^31).
            if (mx_mag == '0) begin
               state_in = ST_OUT;
            end else if (mx_mag[MW-1:31] != '0) begin
               ux_in = ux_ff >> 1;
               uy_in = uy_ff >> 1;
            end else if (!mx_mag[30]) begin
               ux_in = ux_ff << 1;
               uy_in = uy_ff << 1;
            end else begin
               step_in = S_SQX;
               state_in = ST_ISSUE;
            end
         end
         ST_SQRT: begin
            if (sq_ff >= sq_try) begin
               sq_in = sq_ff - sq_try;
               sroot_in = (sroot_ff >> 1) + sbit_ff;
            end else begin
               sroot_in = sroot_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            ucnt_in = ucnt_ff - 6'd1;
            if (ucnt_ff == '0) begin
               step_in = S_OX;
               state_in = ST_ISSUE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.out_x = sat32(ax_ff);
               rsp_data_in.out_y = sat32(ay_ff);
               rsp_data_in.status = st_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      idx_ff <= idx_in;
      qy_ff <= qy_in;
      tx_ff <= tx_in;
      cx_ff <= cx_in; cy_ff <= cy_in; mx_ff <= mx_in; my_ff <= my_in;
      c1x_ff <= c1x_in; c1y_ff <= c1y_in; c2x_ff <= c2x_in; c2y_ff <= c2y_in;
      c3x_ff <= c3x_in; c3y_ff <= c3y_in;
      t_ff <= t_in; h_ff <= h_in; gx_ff <= gx_in;
      ax_ff <= ax_in; ay_ff <= ay_in; st_ff <= st_in;
      ux_ff <= ux_in; uy_ff <= uy_in; gxn_ff <= gxn_in; gyn_ff <= gyn_in;
      sq_ff <= sq_in; sroot_ff <= sroot_in; sbit_ff <= sbit_in;
      mode_ff <= mode_in; ma_ff <= ma_in; mb_ff <= mb_in; prod_ff <= prod_in;
      neg_ff <= neg_in; ucnt_ff <= ucnt_in; dvs_ff <= dvs_in; rem_ff <= rem_in;
      quo_ff <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== dv/tb_map_point_onto_path_core.sv =====
// Testbench for map_point_onto_path_core: drives clears, table loads, unused opcodes and queries over the
// request channel and checks each response against an in-bench path mapping predictor.
// Depends on rtl/mpp_pkg.sv and rtl/map_point_onto_path_core.sv.
`default_nettype none

module tb_map_point_onto_path_core;
   import mpp_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int T_BITS = 30;
   localparam longint SAT_LIM = 64'sd1 <<< 40;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   mpp_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   mpp_rsp_type rsp_data;

   map_point_onto_path_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // Predictor copy of the segment table.
   logic [1:0]         path_kind [MAX_SEGMENTS];
   logic signed [31:0] path_pts  [MAX_SEGMENTS][6];
   logic [30:0]        path_len  [MAX_SEGMENTS];
   int                 path_count = 0;

   mpp_rsp_type pending_rsp[$];
   int  mismatches = 0;
   int  n_query = 0, n_append = 0, n_clear = 0, n_unused = 0, n_checked = 0;
   bit  idle_on = 1'b1;
   bit  hold_rsp = 1'b0;
   int  quiet_cycles = 0;

   function automatic longint clamp_lim(longint v);
      return v > SAT_LIM ? SAT_LIM : (v < -SAT_LIM ? -SAT_LIM : v);
   endfunction

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // a * b / c with truncation toward zero, saturated; c is positive.
   function automatic longint scaled_product(longint a, longint b, longint c);
      bit         neg;
      bit [63:0]  ua, ub;
      bit [127:0] prod, quo;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      if (c <= 0) return 0;
      prod = {64'b0, ua} * {64'b0, ub};
      quo = prod / {64'b0, c};
      if (quo > 128'(SAT_LIM)) quo = 128'(SAT_LIM);
      return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
   endfunction

   function automatic longint mul_t(longint a, longint t);
      return scaled_product(a, t, 64'sd1 <<< T_BITS);
   endfunction

   function automatic bit [63:0] root_floor(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic mpp_rsp_type map_point(longint qx, longint qy);
      mpp_rsp_type r;
      longint tx, cx, cy, mx, my, x, y, ex, ey, ddx, ddy, t;
      longint p [6];
      longint c1x, c1y, c2x, c2y, c3x, c3y, gx, gy, sx, sy;
      bit [63:0] ux, uy, m, n;
      logic [1:0] k;
      longint len;
      int i;
      tx = qx; cx = 0; cy = 0; mx = 0; my = 0; i = 0;
      r.out_x = sat32(qx);
      r.out_y = sat32(qy);
      r.status = STAT_PASS;
      if (path_count == 0) return r;
      while (i + 1 < path_count) begin
         k = path_kind[i];
         len = (k == KIND_MOVE) ? 0 : longint'(path_len[i]);
         if (!(k == KIND_MOVE || tx > len)) break;
         tx -= len;
         if (k == KIND_MOVE) begin
            mx = path_pts[i][0]; my = path_pts[i][1]; cx = mx; cy = my;
         end else if (k == KIND_LINE) begin
            cx = path_pts[i][0]; cy = path_pts[i][1];
         end else if (k == KIND_CURVE) begin
            cx = path_pts[i][4]; cy = path_pts[i][5];
         end else begin
            cx = mx; cy = my;
         end
         i++;
      end
      k = path_kind[i];
      if (k == KIND_MOVE) return r;
      len = longint'(path_len[i]);
      for (int j = 0; j < 6; j++) p[j] = path_pts[i][j];
      x = cx; y = cy;
      if (len != 0 && k != KIND_CURVE) begin
         ex = (k == KIND_LINE) ? p[0] : mx;
         ey = (k == KIND_LINE) ? p[1] : my;
         ddx = ex - cx; ddy = ey - cy;
         x = cx + scaled_product(ddx, tx, len) - scaled_product(ddy, qy, len);
         y = cy + scaled_product(ddy, tx, len) + scaled_product(ddx, qy, len);
      end else if (len != 0) begin
         t = scaled_product(tx, 64'sd1 <<< T_BITS, len);
         c1x = 3 * (p[0] - cx); c1y = 3 * (p[1] - cy);
         c2x = 3 * (p[2] - 2 * p[0] + cx); c2y = 3 * (p[3] - 2 * p[1] + cy);
         c3x = p[4] - 3 * p[2] + 3 * p[0] - cx;
         c3y = p[5] - 3 * p[3] + 3 * p[1] - cy;
         x = cx + mul_t(clamp_lim(mul_t(clamp_lim(mul_t(c3x, t) + c2x), t) + c1x), t);
         y = cy + mul_t(clamp_lim(mul_t(clamp_lim(mul_t(c3y, t) + c2y), t) + c1y), t);
         gx = clamp_lim(mul_t(clamp_lim(mul_t(3 * c3x, t) + 2 * c2x), t) + c1x);
         gy = clamp_lim(mul_t(clamp_lim(mul_t(3 * c3y, t) + 2 * c2y), t) + c1y);
         // Normalize the gradient so its larger component sits in [2^30, 2^31).
         ux = gx < 0 ? -gx : gx;
         uy = gy < 0 ? -gy : gy;
         m = ux > uy ? ux : uy;
         if (m != 0) begin
            while (m >= (64'd1 << 31)) begin m >>= 1; ux >>= 1; uy >>= 1; end
            while (m < (64'd1 << 30)) begin m <<= 1; ux <<= 1; uy <<= 1; end
            n = root_floor(ux * ux + uy * uy);
            sx = gx < 0 ? -longint'(ux) : longint'(ux);
            sy = gy < 0 ? -longint'(uy) : longint'(uy);
            x = x - scaled_product(sy, qy, longint'(n));
            y = y + scaled_product(sx, qy, longint'(n));
         end
      end
      r.out_x = sat32(x);
      r.out_y = sat32(y);
      r.status = STAT_MAPPED;
      return r;
   endfunction

   // Updates the predicted table and queues any response for one accepted request.
   task automatic predict_response(mpp_req_type q);
      mpp_rsp_type r;
      r = '0;
      case (q.opcode)
         OP_CLEAR: begin
            path_count = 0;
            r.status = STAT_CLEARED;
            n_clear++;
         end
         OP_APPEND: begin
            n_append++;
            if (path_count >= MAX_SEGMENTS) begin
               r.status = STAT_FULL;
            end else begin
               path_kind[path_count] = q.seg_kind;
               path_pts[path_count] = '{q.ctrl1_x, q.ctrl1_y, q.ctrl2_x, q.ctrl2_y,
                                        q.end_x, q.end_y};
               path_len[path_count] = q.seg_length;
               path_count++;
               r.status = STAT_STORED;
            end
         end
         OP_QUERY: begin
            n_query++;
            r = map_point(longint'(q.query_x), longint'(q.query_y));
         end
         default: begin
            n_unused++;
            return;
         end
      endcase
      pending_rsp.push_back(r);
   endtask

   task automatic send_item(mpp_req_type q);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_data = q;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_response(q);
      @(negedge clock);
      // A following call without an idle gap raises valid again in this same time step.
      req_valid = 1'b0;
   endtask

   function automatic mpp_req_type random_fill();
      mpp_req_type q;
      logic [319:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      q = raw[$bits(mpp_req_type)-1:0];
      return q;
   endfunction

   function automatic mpp_req_type make_op(logic [1:0] op);
      mpp_req_type q;
      q = random_fill();
      q.opcode = op;
      return q;
   endfunction

   function automatic mpp_req_type make_seg(logic [1:0] kind, int x1, int y1, int x2,
                                            int y2, int ex, int ey, int len);
      mpp_req_type q;
      q = make_op(OP_APPEND);
      q.seg_kind = kind;
      q.ctrl1_x = x1; q.ctrl1_y = y1; q.ctrl2_x = x2; q.ctrl2_y = y2;
      q.end_x = ex; q.end_y = ey; q.seg_length = len[30:0];
      return q;
   endfunction

   function automatic mpp_req_type make_query(int qx, int qy);
      mpp_req_type q;
      q = make_op(OP_QUERY);
      q.query_x = qx; q.query_y = qy;
      return q;
   endfunction

   // Mostly moderate coordinates, sometimes the full 32-bit range.
   function automatic int rand_coord();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
   endfunction

   function automatic int rand_len();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom & 32'h7fffffff;
         default: return $urandom_range(1, 32'h00400000);
      endcase
   endfunction

   // Response side: random ready bursts, or a long hold when requested.
   initial begin
      int hold_count;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready = 1'b0;
         end else if (hold_rsp) begin
            rsp_ready = 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
               hold_rsp = 1'b0;
               hold_count = 0;
            end
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      mpp_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response x=%0d y=%0d status=%0d",
                        rsp_data.out_x, rsp_data.out_y, rsp_data.status);
         end else begin
            want = pending_rsp.pop_front();
            n_checked++;
            if (rsp_data.out_x !== want.out_x || rsp_data.out_y !== want.out_y ||
                rsp_data.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: response %0d: expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
                           n_checked, want.out_x, want.out_y, want.status,
                           rsp_data.out_x, rsp_data.out_y, rsp_data.status);
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, pending_rsp.size());
            $display("tb_map_point_onto_path_core: done, errors");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_item(make_op(OP_CLEAR));
      send_item(make_query(32'sh7fffffff, 32'sh80000000));
      send_item(make_seg(KIND_MOVE, 32'sh10000, 32'sh20000, 0, 0, 0, 0, 32'h7fffffff));
      send_item(make_query(32'sh30000, 32'sh1000));
      send_item(make_op(OP_UNUSED));
      send_item(make_seg(KIND_LINE, 32'sh50000, 32'sh20000, 0, 0, 0, 0, 32'h40000));
      send_item(make_query(32'sh20000, 32'sh8000));
      send_item(make_query(32'sh90000, -32'sh8000));
      send_item(make_query(-32'sh10000, 32'sh10000));
      send_item(make_seg(KIND_LINE, 32'sh50000, 32'sh20000, 0, 0, 0, 0, 0));
      send_item(make_seg(KIND_CURVE, 32'sh60000, 32'sh40000, 32'sh80000, 32'sh40000,
                         32'sh90000, 32'sh10000, 32'h50000));
      send_item(make_query(32'sh48000, 32'sh4000));
      send_item(make_query(32'sh40000, 32'sh4000));
      send_item(make_seg(KIND_CLOSE, 0, 0, 0, 0, 0, 0, 32'h30000));
      send_item(make_query(32'sh7fffffff, 32'sh7fffffff));
      send_item(make_query(32'sh80000000, 32'sh20000));
      // Close before any move returns to the origin; a curve then runs straight from there.
      send_item(make_op(OP_CLEAR));
      send_item(make_seg(KIND_CLOSE, 0, 0, 0, 0, 0, 0, 32'h10000));
      send_item(make_seg(KIND_CURVE, 32'sh70000, 32'sh70000, 32'sh70000, 32'sh70000,
                         32'sh70000, 32'sh70000, 32'h10000));
      send_item(make_query(32'sh18000, 32'sh10000));
      send_item(make_op(OP_CLEAR));
      send_item(make_seg(KIND_LINE, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 1));
      send_item(make_query(32'sh7fffffff, 32'sh7fffffff));
      send_item(make_query(32'sh80000000, 32'sh80000000));
   endtask

   task automatic test_table_full();
      send_item(make_op(OP_CLEAR));
      for (int i = 0; i < MAX_SEGMENTS + 2; i++)
         send_item(make_seg(i[0] ? KIND_LINE : KIND_MOVE, i * 32'sh10000, i * 32'sh800,
                            0, 0, 0, 0, 32'h10000));
      send_item(make_query(32'sh7fff0000, 32'sh100));
      send_item(make_query(-32'sh100, 32'sh100));
   endtask

   task automatic test_response_hold();
      hold_rsp = 1'b1;
      for (int i = 0; i < 24; i++) send_item(make_op(OP_CLEAR));
      wait_drained();
   endtask

   task automatic random_sequence();
      int nseg, nq, total;
      total = 0;
      send_item(make_op(OP_CLEAR));
      nseg = $urandom_range(1, 6);
      if ($urandom_range(0, 4) != 0)
         send_item(make_seg(KIND_MOVE, rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_len()));
      for (int i = 0; i < nseg; i++) begin
         mpp_req_type q;
         q = make_seg(2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_len());
         total += (q.seg_length > 31'h00400000) ? 32'h00400000 : int'(q.seg_length);
         send_item(q);
      end
      nq = $urandom_range(1, 5);
      for (int i = 0; i < nq; i++)
         send_item(make_query($urandom_range(0, 6) == 0 ? int'($urandom) :
                              $signed($urandom_range(0, total + 32'h20000)) - 32'sh10000,
                              rand_coord()));
   endtask

   task automatic test_random(int items);
      int start;
      start = n_query + n_append + n_clear + n_unused;
      while (n_query + n_append + n_clear + n_unused - start < items) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(random_fill());
         end else begin
            random_sequence();
         end
         if ($urandom_range(0, 40) == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_table_full();
      test_response_hold();
      test_random(380);
      wait_drained();
      idle_on = 1'b0;
      test_random(100);
      req_valid = 1'b0;
      wait_drained();
      repeat (1000) @(negedge clock);
      $display("Covered %0d queries, %0d appends, %0d clears and %0d unused opcodes;",
               n_query, n_append, n_clear, n_unused);
      $display("%0d responses checked, including table overflow and output hold-off.",
               n_checked);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("tb_map_point_onto_path_core: done, clean");
      end else begin
         $display("tb_map_point_onto_path_core: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
